// ===== rtl/fixed_point_q24_8_alu_unit_defines.svh =====
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check cons in the cycle after ante.
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
// Types, constants and helpers shared by the fixed-point ALU.
`default_nettype none
package fpa_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 8;
	localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int DIV_STEPS = 2;

	typedef logic [WORD_BITS-1:0] word_t;

	localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_CMP   = 4'd4,
		OP_MIN   = 4'd5,
		OP_MAX   = 4'd6,
		OP_INC   = 4'd7,
		OP_DEC   = 4'd8,
		OP_TOINT = 4'd9
	} opcode_t;

	typedef struct packed {
		opcode_t              op;
		logic                 neg;
		logic                 dz;
		logic                 ovf;
		logic                 lt;
		logic                 eq;
		logic                 gt;
		word_t                res;
		logic [QUOT_BITS-1:0] num;
		word_t                rem;
		word_t                dvs;
		logic [PROD_BITS-1:0] prod;
	} pipe_t;

	typedef struct packed {
		word_t val;
		logic  ovf;
	} sat_t;

	function automatic sat_t pack_sat(input logic neg, input logic [PROD_BITS-1:0] mag);
		logic [PROD_BITS-1:0] limit;
		sat_t r;
		limit = PROD_BITS'(WMAX) + PROD_BITS'(neg);
		if (mag > limit) begin
			r.ovf = 1'b1;
			r.val = neg ? WMIN : WMAX;
		end else begin
			r.ovf = 1'b0;
			r.val = neg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/fpa_in_if.sv =====
// Operand channel: opcode and two Q24.8 operands.
`default_nettype none
interface fpa_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/fpa_out_if.sv =====
// Result channel: Q24.8 result and flags.
`default_nettype none
interface fpa_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        is_less;
	logic        is_equal;
	logic        is_greater;
	logic        overflow;
	logic        div_by_zero;

	modport source (output valid, output result, output is_less, output is_equal,
		output is_greater, output overflow, output div_by_zero, input ready);
	modport sink (input valid, input result, input is_less, input is_equal,
		input is_greater, input overflow, input div_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpa_div_stage.sv =====
// One registered stage of the restoring divider, DIV_STEPS quotient bits per stage.
`default_nettype none
module fpa_div_stage #(
	parameter int DIV_STEPS = fpa_pkg::DIV_STEPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  fpa_pkg::pipe_t in_data,
	output logic          out_valid,
	output fpa_pkg::pipe_t out_data
);
	import fpa_pkg::*;

	pipe_t nxt;

	always_comb begin
		logic [WORD_BITS:0] r;
		logic               bit_q;
		nxt = in_data;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r = {nxt.rem, nxt.num[QUOT_BITS-1]};
			bit_q = (r >= {1'b0, nxt.dvs});
			if (bit_q) begin
				r = r - {1'b0, nxt.dvs};
			end
			nxt.rem = r[WORD_BITS-1:0];
			nxt.num = {nxt.num[QUOT_BITS-2:0], bit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_data <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fixed_point_q24_8_alu_unit.sv =====
// Top level of the pipelined Q24.8 fixed-point ALU.
//
//   channel   | role  | transaction
//   ----------+-------+------------------------------------------------
//   operands  | sink  | opcode, operand_a, operand_b
//   results   | source| result, is_less, is_equal, is_greater, overflow,
//             |       | div_by_zero
//
// Accepts one transaction per cycle unless the result channel stalls; the divider
// chain, DIV_STEPS quotient bits per stage, sets the depth.
// Each stage holds while its successor is full and stalled; bubbles close up.
// Reset clears only the stage valid bits.
`default_nettype none
`include "fixed_point_q24_8_alu_unit_defines.svh"
module fixed_point_q24_8_alu_unit #(
	parameter int DIV_STEPS = fpa_pkg::DIV_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	fpa_in_if.sink      operands,
	fpa_out_if.source   results
);
	import fpa_pkg::*;

	localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;

	typedef struct packed {
		word_t val;
		logic  lt;
		logic  eq;
		logic  gt;
		logic  ovf;
		logic  dz;
	} out_t;

	logic  v_s1, v_s2, res_v_q;
	pipe_t p_s1, p_s2;
	pipe_t nxt_s1, nxt_s2;
	out_t  res_q, res_nxt;
	logic  rdy_s1, rdy_s2, rdy_out;
	logic  [DIV_STAGES-1:0] div_v;
	logic  [DIV_STAGES-1:0] div_rdy;
	pipe_t div_p [DIV_STAGES];
	logic  [2:0] flags;

	// stage 1: decode, compare, add family, min/max, to-integer, magnitudes
	always_comb begin
		word_t a, b, y, mag_a, mag_b, sh;
		logic [WORD_BITS:0] sum;
		logic sub, add_ovf;
		word_t add_res;
		a = operands.operand_a;
		b = operands.operand_b;
		nxt_s1 = '0;
		nxt_s1.op = opcode_t'(operands.opcode);
		nxt_s1.lt = $signed(a) < $signed(b);
		nxt_s1.eq = (a == b);
		nxt_s1.gt = !nxt_s1.lt && !nxt_s1.eq;
		mag_a = a[WORD_BITS-1] ? (~a + 1'b1) : a;
		mag_b = b[WORD_BITS-1] ? (~b + 1'b1) : b;
		y = (nxt_s1.op == OP_INC || nxt_s1.op == OP_DEC) ? word_t'(1) : b;
		sub = (nxt_s1.op == OP_SUB || nxt_s1.op == OP_DEC);
		sum = sub ? ({a[WORD_BITS-1], a} - {y[WORD_BITS-1], y})
			: ({a[WORD_BITS-1], a} + {y[WORD_BITS-1], y});
		add_ovf = sum[WORD_BITS] != sum[WORD_BITS-1];
		add_res = add_ovf ? (sum[WORD_BITS] ? WMIN : WMAX) : sum[WORD_BITS-1:0];
		sh = mag_a >> FRAC_BITS;
		case (nxt_s1.op)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				nxt_s1.res = add_res;
				nxt_s1.ovf = add_ovf;
			end
			OP_MIN:   nxt_s1.res = nxt_s1.lt ? a : b;
			OP_MAX:   nxt_s1.res = nxt_s1.gt ? a : b;
			OP_TOINT: nxt_s1.res = a[WORD_BITS-1] ? (~sh + 1'b1) : sh;
			default:  nxt_s1.res = '0;
		endcase
		nxt_s1.dz = (nxt_s1.op == OP_DIV) && (b == '0);
		nxt_s1.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
		nxt_s1.num = {mag_a, {FRAC_BITS{1'b0}}};
		nxt_s1.dvs = mag_b;
	end

	// stage 2: magnitude product
	always_comb begin
		nxt_s2 = p_s1;
		nxt_s2.prod = {{WORD_BITS{1'b0}}, p_s1.num[QUOT_BITS-1 -: WORD_BITS]}
			* {{WORD_BITS{1'b0}}, p_s1.dvs};
	end

	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_s2 = !v_s2 || div_rdy[0];
	assign rdy_out = !res_v_q || results.ready;
	assign operands.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= operands.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && operands.valid) begin
			p_s1 <= nxt_s1;
		end
		if (rdy_s2 && v_s1) begin
			p_s2 <= nxt_s2;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		if (k == DIV_STAGES - 1) begin : g_last
			assign div_rdy[k] = !div_v[k] || rdy_out;
		end else begin : g_mid
			assign div_rdy[k] = !div_v[k] || div_rdy[k+1];
		end
		if (k == 0) begin : g_first
			fpa_div_stage #(.DIV_STEPS(DIV_STEPS)) u_stage (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (div_rdy[k]),
				.in_valid (v_s2),
				.in_data  (p_s2),
				.out_valid(div_v[k]),
				.out_data (div_p[k])
			);
		end else begin : g_next
			fpa_div_stage #(.DIV_STEPS(DIV_STEPS)) u_stage (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (div_rdy[k]),
				.in_valid (div_v[k-1]),
				.in_data  (div_p[k-1]),
				.out_valid(div_v[k]),
				.out_data (div_p[k])
			);
		end
	end

	// final stage: round, saturate, select
	always_comb begin
		pipe_t p;
		logic [PROD_BITS:0]   psum;
		logic [PROD_BITS-1:0] qmag;
		logic [WORD_BITS:0]   twice;
		logic                 rnd;
		sat_t                 sat;
		p = div_p[DIV_STAGES-1];
		psum = {1'b0, p.prod} + (PROD_BITS+1)'(1 << (FRAC_BITS - 1));
		twice = {p.rem, 1'b0};
		rnd = twice >= {1'b0, p.dvs};
		qmag = PROD_BITS'(p.num) + PROD_BITS'(rnd);
		res_nxt.lt = p.lt;
		res_nxt.eq = p.eq;
		res_nxt.gt = p.gt;
		res_nxt.dz = p.dz;
		res_nxt.val = p.res;
		res_nxt.ovf = p.ovf;
		case (p.op)
			OP_MUL: begin
				sat = pack_sat(p.neg, PROD_BITS'(psum >> FRAC_BITS));
				res_nxt.val = sat.val;
				res_nxt.ovf = sat.ovf;
			end
			OP_DIV: begin
				sat = pack_sat(p.neg, qmag);
				res_nxt.val = p.dz ? '0 : sat.val;
				res_nxt.ovf = p.dz ? 1'b0 : sat.ovf;
			end
			default: begin
				sat = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (rdy_out) begin
			res_v_q <= div_v[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_v[DIV_STAGES-1]) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid       = res_v_q;
	assign results.result      = res_q.val;
	assign results.is_less     = res_q.lt;
	assign results.is_equal    = res_q.eq;
	assign results.is_greater  = res_q.gt;
	assign results.overflow    = res_q.ovf;
	assign results.div_by_zero = res_q.dz;

	assign flags = {res_q.lt, res_q.eq, res_q.gt};

	`FPA_ASSERT_NOW(a_flags_onehot, res_v_q, $onehot(flags), "compare flags not one-hot")
	`FPA_ASSERT_NOW(a_dz_zero, res_v_q && res_q.dz, res_q.val == '0 && !res_q.ovf, "bad divide by zero")
	`FPA_ASSERT_NEXT(a_s1_hold, v_s1 && !rdy_s2, v_s1 && $stable(p_s1), "stage 1 lost on stall")
endmodule
`default_nettype wire

// ===== test/tb_fixed_point_q24_8_alu_unit.sv =====
// Testbench for the Q24.8 fixed-point ALU: directed and random operations against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_fixed_point_q24_8_alu_unit;
	import fpa_pkg::*;

	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] res;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        ovf;
		logic        dz;
	} alu_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fpa_in_if operands();
	fpa_out_if results();

	fixed_point_q24_8_alu_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands.sink),
		.results(results.source)
	);

	alu_req_t pending_ops[$];
	alu_rsp_t expected_rsps[$];
	int error_count = 0;
	int rsp_count = 0;
	int ovf_count = 0;
	int dz_count = 0;
	bit stim_done = 1'b0;
	bit hold_results = 1'b0;
	bit in_taken = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] sat_mag(input logic neg, input logic [127:0] mag,
		inout logic ovf);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (mag > lim) begin
			ovf = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? 32'(-mag) : mag[31:0];
	endfunction

	function automatic alu_rsp_t alu_predict(input alu_req_t q);
		alu_rsp_t r;
		logic signed [31:0] sa, sb;
		logic signed [32:0] sum;
		logic [127:0] ma, mb, prod, num, quo, rem;
		logic neg;
		sa = q.a;
		sb = q.b;
		r = '0;
		r.lt = sa < sb;
		r.eq = sa == sb;
		r.gt = sa > sb;
		ma = sa < 0 ? 128'(-33'(sa)) : 128'(sa);
		mb = sb < 0 ? 128'(-33'(sb)) : 128'(sb);
		neg = sa[31] ^ sb[31];
		case (q.op)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				if (q.op == OP_ADD) sum = 33'(sa) + 33'(sb);
				else if (q.op == OP_SUB) sum = 33'(sa) - 33'(sb);
				else if (q.op == OP_INC) sum = 33'(sa) + 33'sd1;
				else sum = 33'(sa) - 33'sd1;
				if (sum > 33'sh0_7FFF_FFFF) begin
					r.ovf = 1'b1;
					r.res = 32'h7FFF_FFFF;
				end else if (sum < -33'sh0_8000_0000) begin
					r.ovf = 1'b1;
					r.res = 32'h8000_0000;
				end else begin
					r.res = sum[31:0];
				end
			end
			OP_MUL: begin
				prod = (ma * mb + 128'd128) >> FRAC_BITS;
				r.res = sat_mag(neg, prod, r.ovf);
			end
			OP_DIV: begin
				if (sb == 0) begin
					r.dz = 1'b1;
				end else begin
					num = ma << FRAC_BITS;
					quo = num / mb;
					rem = num % mb;
					if (rem >= mb - rem) quo = quo + 1;
					r.res = sat_mag(neg, quo, r.ovf);
				end
			end
			OP_MIN: r.res = r.lt ? q.a : q.b;
			OP_MAX: r.res = r.gt ? q.a : q.b;
			OP_TOINT: r.res = sa[31] ? 32'(-(ma >> FRAC_BITS)) : 32'(ma >> FRAC_BITS);
			default: r.res = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s at %0t: got %h expected %h", what, $time, got, want);
		error_count++;
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 3) << FRAC_BITS;
			3: return -($urandom_range(0, 3) << FRAC_BITS);
			4: return 32'($signed($urandom_range(0, 8191)) - 4096);
			5: return 32'($signed($urandom() >> 12)) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom();
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	int drive_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operands.valid <= 1'b0;
			drive_gap = 0;
		end else if (!operands.valid || in_taken) begin
			if (in_taken) void'(pending_ops.pop_front());
			if (drive_gap > 0) begin
				drive_gap--;
				operands.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				operands.valid <= 1'b1;
				operands.opcode <= pending_ops[0].op;
				operands.operand_a <= pending_ops[0].a;
				operands.operand_b <= pending_ops[0].b;
				drive_gap = rand_gap();
			end else begin
				operands.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		in_taken = arst_n && operands.valid && operands.ready;
		if (in_taken)
			expected_rsps.push_back(alu_predict({operands.opcode, operands.operand_a,
				operands.operand_b}));
	end

	int sink_gap = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			sink_gap = 0;
		end else if (hold_results) begin
			results.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
			sink_gap = rand_gap();
		end
	end

	always @(posedge clk) begin
		alu_rsp_t want;
		if (arst_n && results.valid && results.ready) begin
			rsp_count++;
			if (expected_rsps.size() == 0) begin
				$display("unexpected transaction at %0t", $time);
				error_count++;
			end else begin
				want = expected_rsps.pop_front();
				if (results.result !== want.res)
					report_mismatch("result", results.result, want.res);
				if (results.is_less !== want.lt)
					report_mismatch("is_less", 32'(results.is_less), 32'(want.lt));
				if (results.is_equal !== want.eq)
					report_mismatch("is_equal", 32'(results.is_equal), 32'(want.eq));
				if (results.is_greater !== want.gt)
					report_mismatch("is_greater", 32'(results.is_greater), 32'(want.gt));
				if (results.overflow !== want.ovf)
					report_mismatch("overflow", 32'(results.overflow), 32'(want.ovf));
				if (results.div_by_zero !== want.dz)
					report_mismatch("div_by_zero", 32'(results.div_by_zero), 32'(want.dz));
				ovf_count += int'(want.ovf);
				dz_count += int'(want.dz);
			end
		end
	end

	initial begin
		operands.valid = 1'b0;
		operands.opcode = '0;
		operands.operand_a = '0;
		operands.operand_b = '0;
		results.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	initial begin
		logic [31:0] ext[6];
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h100, 32'hFFFF_FF00, 32'h1};
		for (int op = 0; op < 16; op++)
			pending_ops.push_back({4'(op), ext[op % 6], ext[(op + 2) % 6]});
		pending_ops.push_back({4'(OP_DIV), 32'h7FFF_FFFF, 32'h0});
		pending_ops.push_back({4'(OP_MUL), 32'h8000_0000, 32'h0});
		pending_ops.push_back({4'(OP_MUL), 32'h8000_0000, 32'hFFFF_FF00});
		pending_ops.push_back({4'(OP_DIV), 32'h8000_0000, 32'hFFFF_FF00});
		pending_ops.push_back({4'(OP_INC), 32'h7FFF_FFFF, 32'h0});
		pending_ops.push_back({4'(OP_DEC), 32'h8000_0000, 32'h0});
		pending_ops.push_back({4'(OP_TOINT), 32'hFFFF_FE80, 32'h0});
		pending_ops.push_back({4'(OP_DIV), 32'h0000_0180, 32'h0000_0300});
		pending_ops.push_back({4'(OP_CMP), 32'h5, 32'h5});
		for (int i = 0; i < 1000; i++)
			pending_ops.push_back({($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9)), rand_operand(), rand_operand()});
		wait (arst_n);
		while (pending_ops.size() > 700) @(posedge clk);
		hold_results = 1'b1;
		repeat (120) @(posedge clk);
		hold_results = 1'b0;
		while (pending_ops.size() > 0 || operands.valid) @(posedge clk);
		while (expected_rsps.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d operations, %0d saturated, %0d divides by zero",
			rsp_count, ovf_count, dz_count);
		if (error_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
